[sv/sample_to_file_offset_lookup_defines.svh]
// assertion macros for the sample offset lookup checker
`ifndef SAMPLE_TO_FILE_OFFSET_LOOKUP_DEFINES_SVH
`define SAMPLE_TO_FILE_OFFSET_LOOKUP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STFO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STFO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/stfo_pkg.sv]
// shared types and constants of the sample offset lookup
`timescale 1ns / 1ps
package stfo_pkg;

    localparam int STFO_MAX_SAMPLES = 16384;
    localparam int STFO_MAX_RUNS    = 256;
    localparam int STFO_MAX_CHUNKS  = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = 14;
    localparam int DIV_STEPS  = IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd3;

    typedef enum logic [1:0] {
        REQ_SIZE,
        REQ_RUN,
        REQ_CHUNK,
        REQ_LOOKUP
    } req_kind_t;

    typedef struct packed {
        req_kind_t         req_type;
        logic [IDX_W-1:0]  item_index;
        logic [15:0]       first_chunk;
        logic [15:0]       run_samples_per_chunk;
        logic [62:0]       entry_value;
    } req_t;

    typedef struct packed {
        logic [62:0] sample_offset;
        logic [31:0] sample_bytes;
        logic        chunk_out_of_range;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_FETCH,
        ST_RUN_CUR,
        ST_RUN_CHECK,
        ST_RUN_FETCH_NXT,
        ST_RUN_MUL,
        ST_RUN_CMP,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_FIX_MUL,
        ST_SUM,
        ST_LAST,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic run_fetch;
        logic run_fetch_next;
        logic run_load_cur;
        logic run_mul;
        logic run_adv;
        logic div_init;
        logic div_step;
        logic div_end;
        logic fix_mul;
        logic sum_step;
        logic last_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic runs_zero;
        logic runs_last;
        logic idx_below;
        logic div_done;
        logic fixed_zero;
        logic sum_done;
    } sts_t;

endpackage

[sv/sample_to_file_offset_lookup.sv]
// sample offset lookup: top level joining sequencer and datapath
//
// Input channel req (req_valid/req_stall) carries load words and lookup
// words. A load word writes one entry of the size, run or chunk start table
// if its index lies inside it and gives no result. A lookup word gives one
// word on rsp (rsp_valid/rsp_stall) with the sample's file offset, size and
// the out-of-range flag.
// The run walk reads one run table entry per step and the size sum reads the
// size table one entry per cycle; the chunk divide is a restoring divider.
// One lookup is in flight at a time; req_stall is high while it runs.
// A finished word sits in the output register while rsp_stall is high; a new
// word may be accepted meanwhile, and the next lookup waits at its end until
// the register is free. Configuration writes are to be made only while idle;
// the block itself does not enforce this. Reset clears the configuration
// registers, the output valid and the sequencer; table contents are undefined
// until loaded.
`timescale 1ns / 1ps
module sample_to_file_offset_lookup #(
    parameter int MAX_SAMPLES = stfo_pkg::STFO_MAX_SAMPLES,
    parameter int MAX_RUNS    = stfo_pkg::STFO_MAX_RUNS,
    parameter int MAX_CHUNKS  = stfo_pkg::STFO_MAX_CHUNKS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stfo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stfo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  stfo_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output stfo_pkg::rsp_t                  rsp
);
    import stfo_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stfo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    stfo_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_RUNS    (MAX_RUNS),
        .MAX_CHUNKS  (MAX_CHUNKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

[sv/stfo_ctrl.sv]
// lookup sequencer and output word valid
`timescale 1ns / 1ps
module stfo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  stfo_pkg::req_kind_t req_type,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  stfo_pkg::sts_t    sts,
    output stfo_pkg::cmd_t    cmd
);
    import stfo_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == REQ_LOOKUP)
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.runs_zero ? ST_DIV_INIT : ST_RUN_FETCH;
                    end
                end
            end
            ST_RUN_FETCH:
            begin
                cmd.run_fetch = 1'b1;
                state_next    = ST_RUN_CUR;
            end
            ST_RUN_CUR:
            begin
                cmd.run_load_cur = 1'b1;
                state_next       = ST_RUN_CHECK;
            end
            ST_RUN_CHECK:
            begin
                state_next = sts.runs_last ? ST_DIV_INIT : ST_RUN_FETCH_NXT;
            end
            ST_RUN_FETCH_NXT:
            begin
                cmd.run_fetch      = 1'b1;
                cmd.run_fetch_next = 1'b1;
                state_next         = ST_RUN_MUL;
            end
            ST_RUN_MUL:
            begin
                cmd.run_mul = 1'b1;
                state_next  = ST_RUN_CMP;
            end
            ST_RUN_CMP:
            begin
                if (sts.idx_below)
                    state_next = ST_DIV_INIT;
                else
                begin
                    cmd.run_adv = 1'b1;
                    state_next  = ST_RUN_CHECK;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = sts.fixed_zero ? ST_SUM : ST_FIX_MUL;
            end
            ST_FIX_MUL:
            begin
                cmd.fix_mul = 1'b1;
                state_next  = ST_LAST;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_done)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.last_rd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/stfo_dp.sv]
// tables, run walk, divider, size sum and output word register
`timescale 1ns / 1ps
module stfo_dp #(
    parameter int MAX_SAMPLES = 16384,
    parameter int MAX_RUNS    = 256,
    parameter int MAX_CHUNKS  = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stfo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stfo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  stfo_pkg::req_t                    req,
    input  stfo_pkg::cmd_t                    cmd,
    output stfo_pkg::sts_t                    sts,
    output stfo_pkg::rsp_t                    rsp
);
    import stfo_pkg::*;

    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    logic [31:0] fixed_reg;
    logic [14:0] scount_reg;
    logic [8:0]  rcount_reg;
    logic [10:0] ccount_reg;

    logic [14:0] scl;
    logic [8:0]  rcl;
    logic [10:0] ccl;

    logic [31:0] size_mem  [MAX_SAMPLES];
    logic [31:0] run_mem   [MAX_RUNS];
    logic [62:0] chunk_mem [MAX_CHUNKS];

    logic [31:0] size_rd_reg;
    logic [31:0] run_rd_reg;
    logic [62:0] chunk_rd_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [40:0]      base_reg;
    logic [8:0]       run_i_reg;
    logic [15:0]      cur_first_reg;
    logic [15:0]      cur_spc_reg;
    logic [15:0]      nxt_first_reg;
    logic [15:0]      nxt_spc_reg;
    logic [31:0]      prod_reg;
    logic [IDX_W-1:0] quo_reg;
    logic [16:0]      rem_reg;
    logic [3:0]       div_cnt_reg;
    logic [16:0]      chunk_reg;
    logic [IDX_W-1:0] place_reg;
    logic [IDX_W-1:0] sum_i_reg;
    logic             acc_pend_reg;
    logic             acc_inr_reg;
    logic [45:0]      bytes_reg;
    rsp_t             rsp_reg;

    logic [15:0] rd_first;
    logic [15:0] rd_spc;
    logic [15:0] span;
    logic [31:0] span_prod;
    logic [40:0] base_next;
    logic [9:0]  run_sel;
    logic [16:0] rem_sh;
    logic        rem_ge;
    logic [45:0] fix_prod;
    logic        sum_more;
    logic        oor;
    logic [31:0] sbytes;
    logic        size_we;
    logic        run_we;
    logic        chunk_we;
    logic        size_re;
    logic [SW-1:0] size_addr;

    assign scl = (32'(scount_reg) < 32'(MAX_SAMPLES)) ? scount_reg : 15'(MAX_SAMPLES);
    assign rcl = (32'(rcount_reg) < 32'(MAX_RUNS)) ? rcount_reg : 9'(MAX_RUNS);
    assign ccl = (32'(ccount_reg) < 32'(MAX_CHUNKS)) ? ccount_reg : 11'(MAX_CHUNKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_reg  <= '0;
            scount_reg <= '0;
            rcount_reg <= '0;
            ccount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIXED_SIZE:   fixed_reg  <= cfg_data;
                CFG_SAMPLE_COUNT: scount_reg <= cfg_data[14:0];
                CFG_RUN_COUNT:    rcount_reg <= cfg_data[8:0];
                CFG_CHUNK_COUNT:  ccount_reg <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    // table writes
    assign size_we  = cmd.accept && (req.req_type == REQ_SIZE)
                      && (32'(req.item_index) < 32'(MAX_SAMPLES));
    assign run_we   = cmd.accept && (req.req_type == REQ_RUN)
                      && (32'(req.item_index) < 32'(MAX_RUNS));
    assign chunk_we = cmd.accept && (req.req_type == REQ_CHUNK)
                      && (32'(req.item_index) < 32'(MAX_CHUNKS));

    assign sum_more  = (sum_i_reg != idx_reg);
    assign size_re   = cmd.last_rd || (cmd.sum_step && sum_more);
    assign size_addr = cmd.last_rd ? SW'(32'(idx_reg)) : SW'(32'(sum_i_reg));
    assign run_sel   = cmd.run_fetch_next ? ({1'b0, run_i_reg} + 10'd1) : {1'b0, run_i_reg};

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[SW'(32'(req.item_index))] <= req.entry_value[31:0];
        if (size_re)
            size_rd_reg <= size_mem[size_addr];
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[RW'(32'(req.item_index))] <= {req.first_chunk, req.run_samples_per_chunk};
        if (cmd.run_fetch)
            run_rd_reg <= run_mem[RW'(32'(run_sel))];
    end

    always_ff @(posedge clk)
    begin
        if (chunk_we)
            chunk_mem[CW'(32'(req.item_index))] <= req.entry_value;
        if (cmd.last_rd)
            chunk_rd_reg <= chunk_mem[CW'(32'(chunk_reg))];
    end

    // run entry decode and span product
    assign rd_first  = (run_rd_reg[31:16] == 16'd0) ? 16'd0 : run_rd_reg[31:16] - 16'd1;
    assign rd_spc    = (run_rd_reg[15:0] == 16'd0) ? 16'd1 : run_rd_reg[15:0];
    assign span      = (rd_first > cur_first_reg) ? rd_first - cur_first_reg : 16'd0;
    assign span_prod = {16'd0, span} * {16'd0, cur_spc_reg};
    assign base_next = base_reg + {9'd0, prod_reg};

    // restoring divider step
    assign rem_sh = {rem_reg[15:0], quo_reg[IDX_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, cur_spc_reg});

    assign fix_prod = {32'd0, place_reg} * {14'd0, fixed_reg};

    assign oor    = (chunk_reg >= {6'd0, ccl});
    assign sbytes = (fixed_reg != 32'd0) ? fixed_reg
                  : (({1'b0, idx_reg} < scl) ? size_rd_reg : 32'd0);

    always_ff @(posedge clk)
    begin
        acc_pend_reg <= cmd.sum_step && sum_more;
        if (cmd.start)
        begin
            idx_reg       <= req.item_index;
            base_reg      <= '0;
            run_i_reg     <= '0;
            cur_first_reg <= 16'd0;
            cur_spc_reg   <= 16'd1;
        end
        if (cmd.run_load_cur)
        begin
            cur_first_reg <= rd_first;
            cur_spc_reg   <= rd_spc;
        end
        if (cmd.run_mul)
        begin
            nxt_first_reg <= rd_first;
            nxt_spc_reg   <= rd_spc;
            prod_reg      <= span_prod;
        end
        if (cmd.run_adv)
        begin
            base_reg      <= base_next;
            cur_first_reg <= nxt_first_reg;
            cur_spc_reg   <= nxt_spc_reg;
            run_i_reg     <= run_i_reg + 9'd1;
        end
        if (cmd.div_init)
        begin
            quo_reg     <= idx_reg - base_reg[IDX_W-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? rem_sh - {1'b0, cur_spc_reg} : rem_sh;
            quo_reg     <= {quo_reg[IDX_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 4'd1;
        end
        if (cmd.div_end)
        begin
            chunk_reg <= {1'b0, cur_first_reg} + {3'd0, quo_reg};
            place_reg <= rem_reg[IDX_W-1:0];
            sum_i_reg <= idx_reg - rem_reg[IDX_W-1:0];
            bytes_reg <= '0;
        end
        if (cmd.fix_mul)
            bytes_reg <= fix_prod;
        if (cmd.sum_step && sum_more)
        begin
            sum_i_reg   <= sum_i_reg + 14'd1;
            acc_inr_reg <= ({1'b0, sum_i_reg} < scl);
        end
        if (acc_pend_reg)
            bytes_reg <= bytes_reg + (acc_inr_reg ? {14'd0, size_rd_reg} : 46'd0);
        if (cmd.out_load)
        begin
            rsp_reg.sample_offset      <= oor ? 63'd0 : chunk_rd_reg + {17'd0, bytes_reg};
            rsp_reg.sample_bytes       <= sbytes;
            rsp_reg.chunk_out_of_range <= oor;
        end
    end

    assign sts.runs_zero  = (rcl == 9'd0);
    assign sts.runs_last  = (({1'b0, run_i_reg} + 10'd1) == {1'b0, rcl});
    assign sts.idx_below  = ({27'd0, idx_reg} < base_next);
    assign sts.div_done   = (div_cnt_reg == 4'(DIV_STEPS - 1));
    assign sts.fixed_zero = (fixed_reg == 32'd0);
    assign sts.sum_done   = !sum_more && !acc_pend_reg;

    assign rsp = rsp_reg;

endmodule

[sv/stfo_chk.sv]
// port checker for the sample offset lookup, bound to the top level
`timescale 1ns / 1ps
`include "sample_to_file_offset_lookup_defines.svh"
module stfo_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input stfo_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input stfo_pkg::rsp_t rsp
);
    import stfo_pkg::*;

    `STFO_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp word changed while stalled")
    `STFO_ASSERT_NXT(a_lookup_busy, req_valid && !req_stall && req.req_type == REQ_LOOKUP, req_stall, "lookup did not hold off the next word")
    `STFO_ASSERT_NXT(a_load_free, req_valid && !req_stall && req.req_type != REQ_LOOKUP, !req_stall, "load word left the block busy")
    `STFO_ASSERT_NOW(a_oor_zero, rsp_valid && rsp.chunk_out_of_range, rsp.sample_offset == 63'd0, "out of range word with nonzero offset")

endmodule

bind sample_to_file_offset_lookup stfo_chk u_chk (.*);

[tb/sv/tb_top.sv]
// self-checking testbench of the sample offset lookup: table loads, lookups, register phases
`timescale 1ns / 1ps
module tb_top;
    import stfo_pkg::*;

    localparam int IDLE_LIMIT = 150000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    sample_to_file_offset_lookup u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // shadow of registers and tables
    logic [31:0] fixed_size;
    logic [14:0] sample_cnt;
    logic [8:0]  run_cnt;
    logic [10:0] chunk_cnt;
    logic [31:0] size_mem [STFO_MAX_SAMPLES];
    bit          size_loaded [STFO_MAX_SAMPLES];
    logic [31:0] run_mem [STFO_MAX_RUNS];
    bit          run_loaded [STFO_MAX_RUNS];
    logic [62:0] start_mem [STFO_MAX_CHUNKS];
    bit          start_loaded [STFO_MAX_CHUNKS];

    req_t pending_words [$];
    rsp_t expected_lookups [$];
    int words_sent;
    int words_taken;
    int results_seen;
    int mismatches;
    int lookups_made;
    int oor_seen;
    int idle_cycles;
    int req_gap;
    int rsp_gap;
    bit calm;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(20, 4);
        return $urandom_range(200, 50);
    endfunction

    function automatic longint unsigned run_first_of(logic [31:0] w);
        return (w[31:16] == 16'd0) ? 0 : longint'(w[31:16]) - 1;
    endfunction

    function automatic longint unsigned run_spc_of(logic [31:0] w);
        return (w[15:0] == 16'd0) ? 1 : longint'(w[15:0]);
    endfunction

    // computes the lookup result; returns 0 if it would read an entry never loaded
    function automatic bit predict_lookup(input logic [13:0] sample, output rsp_t r);
        longint unsigned runs, chunks, sc, base, chunk, spc, nxt, span, nb;
        longint unsigned whole, place, bytes, s, ix, i;
        bit ok;
        bit oor;
        ok = 1;
        runs = (run_cnt > STFO_MAX_RUNS) ? STFO_MAX_RUNS : run_cnt;
        chunks = (chunk_cnt > STFO_MAX_CHUNKS) ? STFO_MAX_CHUNKS : chunk_cnt;
        sc = (sample_cnt > STFO_MAX_SAMPLES) ? STFO_MAX_SAMPLES : sample_cnt;
        base = 0;
        chunk = 0;
        spc = 1;
        bytes = 0;
        ix = sample;
        for (i = 0; i < runs; i++)
        begin
            if (!run_loaded[i])
                ok = 0;
            chunk = run_first_of(run_mem[i]);
            spc = run_spc_of(run_mem[i]);
            if (i + 1 == runs)
                break;
            if (!run_loaded[i+1])
                ok = 0;
            nxt = run_first_of(run_mem[i+1]);
            span = (nxt > chunk) ? nxt - chunk : 0;
            nb = base + span * spc;
            if (ix < nb)
                break;
            base = nb;
        end
        whole = (ix - base) / spc;
        place = (ix - base) - whole * spc;
        chunk = chunk + whole;
        if (fixed_size != 0)
            bytes = place * longint'(fixed_size);
        else
        begin
            for (s = ix - place; s < ix; s++)
            begin
                if (s < sc)
                begin
                    if (!size_loaded[s])
                        ok = 0;
                    bytes = bytes + size_mem[s];
                end
            end
        end
        oor = (chunk >= chunks);
        r.chunk_out_of_range = oor;
        if (oor)
            r.sample_offset = '0;
        else
        begin
            if (!start_loaded[chunk])
                ok = 0;
            r.sample_offset = start_mem[chunk] + bytes;
        end
        if (fixed_size != 0)
            r.sample_bytes = fixed_size;
        else if (ix < sc)
        begin
            if (!size_loaded[ix])
                ok = 0;
            r.sample_bytes = size_mem[ix];
        end
        else
            r.sample_bytes = '0;
        return ok;
    endfunction

    // queues one word; loads update the shadow, unsafe lookups are dropped
    function automatic bit queue_word(req_t w);
        rsp_t r;
        case (w.req_type)
            REQ_SIZE:
            begin
                size_mem[w.item_index] = w.entry_value[31:0];
                size_loaded[w.item_index] = 1;
            end
            REQ_RUN:
            begin
                if (w.item_index < STFO_MAX_RUNS)
                begin
                    run_mem[w.item_index] = {w.first_chunk, w.run_samples_per_chunk};
                    run_loaded[w.item_index] = 1;
                end
            end
            REQ_CHUNK:
            begin
                if (w.item_index < STFO_MAX_CHUNKS)
                begin
                    start_mem[w.item_index] = w.entry_value;
                    start_loaded[w.item_index] = 1;
                end
            end
            default:
            begin
                if (!predict_lookup(w.item_index, r))
                    return 0;
                expected_lookups.push_back(r);
                lookups_made++;
                if (r.chunk_out_of_range)
                    oor_seen++;
            end
        endcase
        pending_words.push_back(w);
        return 1;
    endfunction

    function automatic req_t make_word(req_kind_t k, int idx, int fc, int spc, logic [62:0] v);
        req_t w;
        w.req_type = k;
        w.item_index = idx[13:0];
        w.first_chunk = fc[15:0];
        w.run_samples_per_chunk = spc[15:0];
        w.entry_value = v;
        return w;
    endfunction

    function automatic logic [62:0] rand63();
        return {$urandom, $urandom};
    endfunction

    function automatic void add_lookup(int lim);
        int tries;
        bit ok;
        ok = 0;
        for (tries = 0; tries < 20 && !ok; tries++)
            ok = queue_word(make_word(REQ_LOOKUP, $urandom_range(lim), $urandom, $urandom,
                rand63()));
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || req_valid || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_FIXED_SIZE:   fixed_size = v;
            CFG_SAMPLE_COUNT: sample_cnt = v[14:0];
            CFG_RUN_COUNT:    run_cnt = v[8:0];
            default:          chunk_cnt = v[10:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one register setting with freshly loaded tables and a batch of lookups
    task automatic run_phase(int nr, int ns, int n_look, bit sane);
        int i, fc, nc, lim, r;
        bit dummy;
        wait_idle();
        fc = 1;
        for (i = 0; i < nr; i++)
        begin
            if (sane)
            begin
                dummy = queue_word(make_word(REQ_RUN, i, fc, $urandom_range(6), rand63()));
                fc += $urandom_range(3, 1);
            end
            else
                dummy = queue_word(make_word(REQ_RUN, i, $urandom_range(40),
                    ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(4), rand63()));
        end
        nc = sane ? fc + $urandom_range(4) : 44;
        if (nc > STFO_MAX_CHUNKS)
            nc = STFO_MAX_CHUNKS;
        for (i = 0; i < nc; i++)
            dummy = queue_word(make_word(REQ_CHUNK, i, $urandom, $urandom,
                ($urandom_range(9) == 0) ? {63{1'b1}} : rand63()));
        for (i = 0; i < ns; i++)
            dummy = queue_word(make_word(REQ_SIZE, i, $urandom, $urandom,
                ($urandom_range(7) == 0) ? {$urandom, 31'h7fffffff, 1'b1} : rand63()));
        wait_idle();
        r = $urandom_range(9);
        write_reg(CFG_FIXED_SIZE, (r < 6) ? 32'd0 : (r < 8) ? $urandom : 32'hffffffff);
        r = $urandom_range(9);
        write_reg(CFG_SAMPLE_COUNT, (r < 7) ? ns : (r < 8) ? $urandom_range(ns) :
            (r < 9) ? 32'd16384 : 32'h7fff);
        r = $urandom_range(9);
        write_reg(CFG_RUN_COUNT, (r < 8) ? nr : (r < 9) ? 32'd0 : 32'h1ff);
        r = $urandom_range(9);
        write_reg(CFG_CHUNK_COUNT, (r < 7) ? nc : (r < 9) ? $urandom_range(nc) : 32'h7ff);
        calm = ($urandom_range(3) == 0);
        lim = ns + 24;
        for (i = 0; i < n_look; i++)
        begin
            r = $urandom_range(19);
            if (r == 0)
                dummy = queue_word(make_word(REQ_RUN, $urandom_range(16383, 256), $urandom,
                    $urandom, rand63()));
            else if (r == 1)
                dummy = queue_word(make_word(REQ_CHUNK, $urandom_range(16383, 1024), $urandom,
                    $urandom, rand63()));
            else if (r == 2)
                add_lookup(16383);
            else
                add_lookup(lim);
        end
    endtask

    // request side driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || words_taken == words_sent)
        begin
            if (req_gap > 0)
            begin
                req_gap <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                req <= pending_words.pop_front();
                req_valid <= 1'b1;
                words_sent <= words_sent + 1;
                req_gap <= pick_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result side stall
    always @(negedge clk)
    begin
        if (rsp_gap > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_gap <= rsp_gap - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (rsp_valid)
                rsp_gap <= pick_gap();
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (req_valid && !req_stall)
                words_taken <= words_taken + 1;
            if (rsp_valid && !rsp_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_lookups.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word: %h", rsp);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (rsp.sample_offset !== want.sample_offset
                        || rsp.sample_bytes !== want.sample_bytes
                        || rsp.chunk_out_of_range !== want.chunk_out_of_range)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("lookup mismatch: exp off=%h bytes=%h oor=%b, got off=%h bytes=%h oor=%b",
                                want.sample_offset, want.sample_bytes, want.chunk_out_of_range,
                                rsp.sample_offset, rsp.sample_bytes, rsp.chunk_out_of_range);
                    end
                end
            end
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        bit dummy;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        words_sent = 0;
        words_taken = 0;
        results_seen = 0;
        mismatches = 0;
        lookups_made = 0;
        oor_seen = 0;
        idle_cycles = 0;
        req_gap = 0;
        rsp_gap = 0;
        calm = 0;
        fixed_size = '0;
        sample_cnt = '0;
        run_cnt = '0;
        chunk_cnt = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tables, no runs, chunks out of range
        dummy = queue_word(make_word(REQ_LOOKUP, 0, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 16383, 16'hffff, 16'hffff, {63{1'b1}}));
        // loads at extremes and beyond the tables
        dummy = queue_word(make_word(REQ_SIZE, 0, 0, 0, '0));
        dummy = queue_word(make_word(REQ_SIZE, 1, 0, 0, {63{1'b1}}));
        dummy = queue_word(make_word(REQ_SIZE, 16383, 0, 0, 63'h1234));
        dummy = queue_word(make_word(REQ_RUN, 0, 0, 0, '0));
        dummy = queue_word(make_word(REQ_RUN, 1, 16'hffff, 16'hffff, '0));
        dummy = queue_word(make_word(REQ_RUN, 300, 5, 5, '0));
        dummy = queue_word(make_word(REQ_CHUNK, 0, 0, 0, {63{1'b1}}));
        dummy = queue_word(make_word(REQ_CHUNK, 1, 0, 0, '0));
        dummy = queue_word(make_word(REQ_CHUNK, 16383, 0, 0, 63'h55));
        wait_idle();
        // zero first chunk and zero samples per chunk
        write_reg(CFG_FIXED_SIZE, 32'd0);
        write_reg(CFG_SAMPLE_COUNT, 32'd2);
        write_reg(CFG_RUN_COUNT, 32'd1);
        write_reg(CFG_CHUNK_COUNT, 32'd2);
        dummy = queue_word(make_word(REQ_LOOKUP, 0, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 1, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 2, 0, 0, '0));
        dummy = queue_word(make_word(REQ_RUN, 0, 1, 2, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 1, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 3, 0, 0, '0));
        wait_idle();
        // two runs, sample beyond the size table
        write_reg(CFG_RUN_COUNT, 32'd2);
        dummy = queue_word(make_word(REQ_LOOKUP, 0, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 5, 0, 0, '0));
        wait_idle();
        write_reg(CFG_FIXED_SIZE, 32'hffffffff);
        dummy = queue_word(make_word(REQ_LOOKUP, 1, 0, 0, '0));
        dummy = queue_word(make_word(REQ_LOOKUP, 16383, 0, 0, '0));

        run_phase(256, 40, 60, 1);
        for (p = 0; p < 3; p++)
            run_phase($urandom_range(12, 1), $urandom_range(64, 4), 45, ($urandom_range(4) != 0));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d words: %0d lookups (%0d chunk out of range), %0d results",
            words_taken, lookups_made, oor_seen, results_seen);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_lookups.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/stfo_pkg.sv
sv/stfo_ctrl.sv
sv/stfo_dp.sv
sv/sample_to_file_offset_lookup.sv
sv/stfo_chk.sv
tb/sv/tb_top.sv
